FILE: rtl/sha1md_pkg.sv
package sha1md_pkg;

	// Word and digest geometry.
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned ROUNDS       = 80;
	localparam int unsigned ROUND_W      = $clog2(ROUNDS + 1);
	localparam int unsigned FILL_W       = $clog2(BLOCK_WORDS);
	localparam int unsigned IDX_W        = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] chain_t;

	// Initial chaining value.
	localparam chain_t INIT_CHAIN = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	// Round constants.
	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	// Word that opens the padding when the message ends on a word boundary.
	localparam word_t PAD_WORD = 32'h8000_0000;

	// Fill levels at which the length words go in.
	localparam logic [FILL_W-1:0] FILL_LEN_HI = FILL_W'(BLOCK_WORDS - 2);
	localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(BLOCK_WORDS - 1);

	localparam logic [ROUND_W-1:0] RND_LAST = ROUND_W'(ROUNDS);

	// Commands from the sequencer to the compression unit.
	typedef struct packed {
		logic  push;
		word_t word;
		logic  reinit;
	} cmp_ctrl_t;

	// Status of the compression unit.
	typedef struct packed {
		logic              busy;
		logic [FILL_W-1:0] fill;
	} cmp_stat_t;

	function automatic word_t rotl1(input word_t x);
		return {x[WORD_W-2:0], x[WORD_W-1]};
	endfunction

	function automatic word_t rotl5(input word_t x);
		return {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
	endfunction

	function automatic word_t rotl30(input word_t x);
		return {x[1:0], x[WORD_W-1:2]};
	endfunction

endpackage

FILE: rtl/sha1md_compress.sv
module sha1md_compress (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1md_pkg::cmp_ctrl_t ctrl,
	output sha1md_pkg::cmp_stat_t stat,
	output sha1md_pkg::chain_t    chain
);

	// Message schedule as a 16-tap shift line; tap 0 is the current word.
	sha1md_pkg::word_t w_q [sha1md_pkg::BLOCK_WORDS];
	sha1md_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	sha1md_pkg::chain_t chain_q;
	logic [sha1md_pkg::FILL_W-1:0]  fill_q;
	logic [sha1md_pkg::ROUND_W-1:0] rnd_q;
	logic busy_q;

	sha1md_pkg::word_t f_c, k_c, t_c, w_next_c, shift_in_c;
	logic shift_c;

	// Round function and constant selection by round number.
	always_comb begin
		priority if (rnd_q < sha1md_pkg::ROUND_W'(20)) begin
			f_c = (b_q & c_q) | (~b_q & d_q);
			k_c = sha1md_pkg::K0;
		end else if (rnd_q < sha1md_pkg::ROUND_W'(40)) begin
			f_c = b_q ^ c_q ^ d_q;
			k_c = sha1md_pkg::K1;
		end else if (rnd_q < sha1md_pkg::ROUND_W'(60)) begin
			f_c = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_c = sha1md_pkg::K2;
		end else begin
			f_c = b_q ^ c_q ^ d_q;
			k_c = sha1md_pkg::K3;
		end
		t_c = sha1md_pkg::rotl5(a_q) + f_c + e_q + k_c + w_q[0];
		w_next_c = sha1md_pkg::rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
	end

	// The schedule line shifts on every pushed word and on every round.
	assign shift_c    = (ctrl.push && !busy_q) || (busy_q && (rnd_q != sha1md_pkg::RND_LAST));
	assign shift_in_c = busy_q ? w_next_c : ctrl.word;

	always_ff @(posedge clk) begin
		if (shift_c) begin
			for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[sha1md_pkg::BLOCK_WORDS-1] <= shift_in_c;
		end
	end

	// Working variables: loaded when the block fills, updated once per round.
	always_ff @(posedge clk) begin
		if (!busy_q && ctrl.push && (fill_q == sha1md_pkg::FILL_FULL)) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (busy_q && (rnd_q != sha1md_pkg::RND_LAST)) begin
			a_q <= t_c;
			b_q <= a_q;
			c_q <= sha1md_pkg::rotl30(b_q);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Sequencer: fill count, round counter and the chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha1md_pkg::INIT_CHAIN;
			fill_q  <= '0;
			rnd_q   <= '0;
			busy_q  <= 1'b0;
		end else if (busy_q) begin
			if (rnd_q == sha1md_pkg::RND_LAST) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				busy_q     <= 1'b0;
			end else begin
				rnd_q <= rnd_q + 1'b1;
			end
		end else if (ctrl.reinit) begin
			chain_q <= sha1md_pkg::INIT_CHAIN;
			fill_q  <= '0;
		end else if (ctrl.push) begin
			fill_q <= fill_q + 1'b1;
			if (fill_q == sha1md_pkg::FILL_FULL) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.fill = fill_q;
	assign chain     = chain_q;

	// A compression always starts at an empty block and round zero.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> (fill_q == '0) && (rnd_q == '0))
		else $error("compression started with a partial block");

	// The round counter never runs past the final add.
	a_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rnd_q <= sha1md_pkg::RND_LAST))
		else $error("round counter out of range");

	// The busy window ends only after the final add cycle.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> ($past(rnd_q) == sha1md_pkg::RND_LAST))
		else $error("compression ended early");

endmodule

FILE: rtl/sha1_message_digest.sv
// SHA-1 digest of a byte message.
// Input channel (data_valid/data_ready): one transaction per 32-bit big-endian
// message word with data_word, valid_bytes and last_word. Every word but the
// last carries four bytes; the last word holds 0 to 4 valid leading bytes
// (5 to 7 count as 4).
// Output channel (digest_valid/digest_ready): five transactions per message,
// digest_index 0 (most significant) to 4, digest_last set on index 4.
// Flow: data_ready stays high after a word that neither completes a 16-word
// block nor ends the message. The word that completes a block starts the shared
// round unit, which runs one round per cycle: 80 rounds plus one chaining add,
// after which control returns to the sequencer. After the last word the padding
// words go in at one per cycle, pausing for each of the one or two block
// compressions, then the digest is offered. data_ready is low from the
// completing word until the sequencer is idle again, during padding and while
// the digest waits.
// If the receiver stalls, the digest word and its index hold until taken;
// after the fifth transaction the block returns to its initial state.
// Reset loads the initial chaining value and clears the fill count and bit count at once.
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HASH = 4'b0010,
		ST_PAD  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [63:0] bits_q;
	logic pad_q, pend80_q, hi_done_q, done_q;
	logic [sha1md_pkg::IDX_W-1:0] idx_q;

	sha1md_pkg::cmp_ctrl_t ctrl_c;
	sha1md_pkg::cmp_stat_t stat_c;
	sha1md_pkg::chain_t    chain_c;

	logic in_acc_c, out_acc_c, full_c;
	logic [2:0] nb_c;
	sha1md_pkg::word_t last_word_c, pad_word_c;

	sha1md_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_c),
		.stat   (stat_c),
		.chain  (chain_c)
	);

	assign data_ready   = (state_q == ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign in_acc_c     = data_valid && data_ready;
	assign out_acc_c    = digest_valid && digest_ready;
	assign full_c       = (stat_c.fill == sha1md_pkg::FILL_FULL);

	// Clamp the byte count and splice the 0x80 marker into a short last word.
	always_comb begin
		nb_c = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
		unique case (nb_c)
			3'd0:    last_word_c = 32'h8000_0000;
			3'd1:    last_word_c = {data_word[31:24], 24'h80_0000};
			3'd2:    last_word_c = {data_word[31:16], 16'h8000};
			3'd3:    last_word_c = {data_word[31:8], 8'h80};
			default: last_word_c = data_word;
		endcase
	end

	// Padding word chosen for the current fill level.
	always_comb begin
		priority if (pend80_q) begin
			pad_word_c = sha1md_pkg::PAD_WORD;
		end else if (hi_done_q) begin
			pad_word_c = bits_q[31:0];
		end else if (stat_c.fill == sha1md_pkg::FILL_LEN_HI) begin
			pad_word_c = bits_q[63:32];
		end else begin
			pad_word_c = '0;
		end
	end

	// Commands to the compression unit.
	always_comb begin
		ctrl_c.push   = in_acc_c || (state_q == ST_PAD);
		ctrl_c.word   = (state_q == ST_PAD) ? pad_word_c
		              : (last_word ? last_word_c : data_word);
		ctrl_c.reinit = out_acc_c && (idx_q == sha1md_pkg::IDX_W'(sha1md_pkg::DIGEST_WORDS - 1));
	end

	// Message sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bits_q    <= '0;
			pad_q     <= 1'b0;
			pend80_q  <= 1'b0;
			hi_done_q <= 1'b0;
			done_q    <= 1'b0;
			idx_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc_c) begin
						bits_q   <= bits_q + {58'd0, (last_word ? nb_c : 3'd4), 3'd0};
						pad_q    <= last_word;
						pend80_q <= last_word && (nb_c == 3'd4);
						if (full_c) begin
							state_q <= ST_HASH;
						end else if (last_word) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_HASH: begin
					if (!stat_c.busy) begin
						priority if (done_q) begin
							state_q <= ST_OUT;
						end else if (pad_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					priority if (pend80_q) begin
						pend80_q <= 1'b0;
					end else if (hi_done_q) begin
						done_q <= 1'b1;
					end else if (stat_c.fill == sha1md_pkg::FILL_LEN_HI) begin
						hi_done_q <= 1'b1;
					end else begin
						hi_done_q <= 1'b0;
					end
					if (full_c) begin
						state_q <= ST_HASH;
					end
				end
				ST_OUT: begin
					if (out_acc_c) begin
						if (ctrl_c.reinit) begin
							state_q   <= ST_IDLE;
							bits_q    <= '0;
							pad_q     <= 1'b0;
							hi_done_q <= 1'b0;
							done_q    <= 1'b0;
							idx_q     <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Digest words come straight from the held chaining value.
	assign digest_word  = chain_c[idx_q];
	assign digest_index = idx_q;
	assign digest_last  = (idx_q == sha1md_pkg::IDX_W'(sha1md_pkg::DIGEST_WORDS - 1));

	// The round unit only runs while the sequencer waits for it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat_c.busy |-> (state_q == ST_HASH))
		else $error("round unit busy outside the hash wait");

	// A digest always begins at its most significant word.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> (digest_index == '0))
		else $error("digest did not start at index zero");

	// The digest is offered only after both length words went in.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> done_q && hi_done_q && (stat_c.fill == '0))
		else $error("digest offered before the length was hashed");

	// Input and output are never open at the same time.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(data_ready && digest_valid))
		else $error("input ready while digest pending");

endmodule

FILE: tb/sv/sha1_message_digest_test.sv
`timescale 1ns / 1ps

module sha1_message_digest_test;

	localparam int unsigned FULL_BYTES   = 4;
	localparam int unsigned LEN_HI_SLOT  = 14;
	localparam int unsigned TAIL_CYCLES  = 400;
	localparam int unsigned PHASE_WORDS  = 120;

	typedef sha1md_pkg::word_t word_t;

	// One digest word as it leaves the output channel.
	typedef struct {
		word_t      word;
		logic [2:0] index;
		logic       last;
	} digest_t;

	// Scoreboard: a software SHA-1 that follows every accepted word and keeps
	// the digest words that the block still owes.
	class digest_scoreboard;
		word_t       chain[5];
		word_t       block[16];
		int unsigned fill;
		logic [63:0] bit_count;
		digest_t     pending_digests[$];
		int unsigned mismatches;
		int unsigned words_seen;
		int unsigned messages_seen;
		int unsigned digests_checked;

		function new();
			mismatches      = 0;
			words_seen      = 0;
			messages_seen   = 0;
			digests_checked = 0;
			restart();
		endfunction

		// Return to the initial chaining value for the next message.
		function void restart();
			for (int i = 0; i < 5; i++)
				chain[i] = sha1md_pkg::INIT_CHAIN[i];
			for (int i = 0; i < 16; i++)
				block[i] = '0;
			fill      = 0;
			bit_count = '0;
		endfunction

		function word_t rotl(word_t x, int unsigned n);
			return (x << n) | (x >> (32 - n));
		endfunction

		// Expand the current block and fold 80 rounds into the chain.
		function void compress();
			word_t w[80];
			word_t a, b, c, d, e, f, k, t;
			for (int i = 0; i < 16; i++)
				w[i] = block[i];
			for (int i = 16; i < 80; i++)
				w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d);
					k = sha1md_pkg::K0;
				end else if (i < 40) begin
					f = b ^ c ^ d;
					k = sha1md_pkg::K1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = sha1md_pkg::K2;
				end else begin
					f = b ^ c ^ d;
					k = sha1md_pkg::K3;
				end
				t = rotl(a, 5) + f + e + k + w[i];
				e = d;
				d = c;
				c = rotl(b, 30);
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void push(word_t w);
			block[fill] = w;
			fill = (fill + 1) % 16;
			if (fill == 0)
				compress();
		endfunction

		// Account for one accepted input transaction.
		function void note_word(word_t w, logic [2:0] nb, logic lw);
			int unsigned nbytes;
			word_t       keep;
			digest_t     item;
			words_seen++;
			// Words before the last always carry four bytes.
			if (!lw) begin
				push(w);
				bit_count += 64'd32;
				return;
			end
			nbytes = (nb > FULL_BYTES) ? FULL_BYTES : nb;
			bit_count += 64'(nbytes) * 64'd8;
			// The padding byte goes right after the last valid byte.
			if (nbytes == FULL_BYTES) begin
				push(w);
				push(sha1md_pkg::PAD_WORD);
			end else begin
				keep = (nbytes == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
				push((w & keep) | (32'h80 << (24 - 8 * nbytes)));
			end
			while (fill != LEN_HI_SLOT)
				push('0);
			push(bit_count[63:32]);
			push(bit_count[31:0]);
			for (int i = 0; i < 5; i++) begin
				item.word  = chain[i];
				item.index = 3'(i);
				item.last  = (i == 4);
				pending_digests.push_back(item);
			end
			messages_seen++;
			restart();
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		// Compare one output transaction with the oldest owed digest word.
		task check_digest(word_t w, logic [2:0] idx, logic lst);
			digest_t want;
			if (pending_digests.size() == 0) begin
				report($sformatf("unexpected digest word %h index %0d", w, idx));
				return;
			end
			want = pending_digests.pop_front();
			digests_checked++;
			if (w !== want.word)
				report($sformatf("digest_word %h, expected %h (index %0d)",
					w, want.word, want.index));
			if (idx !== want.index)
				report($sformatf("digest_index %0d, expected %0d", idx, want.index));
			if (lst !== want.last)
				report($sformatf("digest_last %b, expected %b (index %0d)",
					lst, want.last, want.index));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        data_valid;
	logic        data_ready;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last_word;
	logic        digest_valid;
	logic        digest_ready;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;

	digest_scoreboard sb;
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	int unsigned      words_sent;

	sha1_message_digest uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.last_word    (last_word),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_last  (digest_last)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Observe both channels at the clock edge and drive a random ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (digest_valid && digest_ready)
				sb.check_digest(digest_word, digest_index, digest_last);
			if (data_valid && data_ready)
				sb.note_word(data_word, valid_bytes, last_word);
		end
		digest_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Offer one word, with a random gap first, and wait for its transaction.
	task automatic send_word(input word_t w, input logic [2:0] nb, input logic lw);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid  <= 1'b1;
		data_word   <= w;
		valid_bytes <= nb;
		last_word   <= lw;
		@(posedge clk);
		while (!data_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// A whole message of random content; short counts on inner words are noise.
	task automatic send_random_message(input int unsigned n_words);
		word_t      w;
		logic [2:0] nb;
		int unsigned pick;
		for (int unsigned i = 0; i < n_words; i++) begin
			pick = $urandom_range(0, 15);
			w = (pick == 0) ? '1 : (pick == 1) ? '0 : word_t'($urandom);
			if (i + 1 == n_words)
				nb = 3'($urandom_range(0, 7));
			else
				nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'(FULL_BYTES);
			send_word(w, nb, i + 1 == n_words);
		end
	endtask

	// Message lengths cluster around the padding boundary now and then.
	function automatic int unsigned random_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 12);
		if (r < 85)
			return $urandom_range(13, 17);
		if (r < 95)
			return $urandom_range(18, 33);
		return $urandom_range(34, 48);
	endfunction

	task automatic random_phase(input int unsigned s_pct, input int unsigned r_pct);
		int unsigned target;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		target = words_sent + PHASE_WORDS;
		while (words_sent < target)
			send_random_message(random_length());
	endtask

	// Main sequence: reset, directed messages, three random phases, drain.
	initial begin
		sb            = new();
		send_idle_pct = 37;
		recv_idle_pct = 86;
		words_sent    = 0;
		arst_n        = 1'b0;
		data_valid    <= 1'b0;
		data_word     <= '0;
		valid_bytes   <= '0;
		last_word     <= 1'b0;
		digest_ready  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message whose word content must be dropped.
		send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
		// One, three and four byte messages.
		send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
		send_word(32'h0000_0000, 3'd3, 1'b1);
		send_word(32'h6162_6364, 3'd4, 1'b1);
		// Counts above four on the last word act as a full word.
		send_word(32'hA5A5_5A5A, 3'd5, 1'b1);
		send_word(32'h1234_5678, 3'd6, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
		// A short count on an inner word is ignored.
		send_word(32'h0000_0000, 3'd0, 1'b0);
		send_word(32'hDEAD_BEEF, 3'd2, 1'b1);
		// Sixteen full words: one data block and one block of padding only.
		send_word(32'hFFFF_FFFF, 3'd6, 1'b0);
		for (int i = 1; i < 15; i++)
			send_word(word_t'($urandom), 3'(FULL_BYTES), 1'b0);
		send_word(32'h0000_0000, 3'(FULL_BYTES), 1'b1);

		random_phase(37, 86);
		random_phase(86, 37);
		random_phase(0, 0);

		data_valid <= 1'b0;
		while (sb.pending_digests.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending_digests.size() != 0)
			sb.report($sformatf("%0d digest words never arrived",
				sb.pending_digests.size()));

		$display("Hashed %0d messages from %0d words and checked %0d digest words.",
			sb.messages_seen, sb.words_seen, sb.digests_checked);
		$display("Mismatches found: %0d.", sb.mismatches);
		if (sb.mismatches == 0)
			$display("sha1_message_digest_test: PASS");
		else
			$display("sha1_message_digest_test: FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("Run did not finish in time.");
		$display("sha1_message_digest_test: FAIL");
		$finish;
	end

endmodule

FILE: sha1_message_digest.f
rtl/sha1md_pkg.sv
rtl/sha1md_compress.sv
rtl/sha1_message_digest.sv
tb/sv/sha1_message_digest_test.sv
